FILE: src/tls_client_hello_sni_extractor_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the server name extractor
// ---------------------------------------------------------------------------
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH

// implication checked on every edge outside reset
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/tcs_pkg.sv
// ---------------------------------------------------------------------------
// tcs_pkg
// shared types and constants of the server name extractor
// ---------------------------------------------------------------------------
package tcs_pkg;

  localparam int unsigned MaxNamesDefault     = 4;
  localparam int unsigned PositionBitsDefault = 16;

  localparam logic [2:0] VerdictOk        = 3'd0;
  localparam logic [2:0] VerdictNoName    = 3'd1;
  localparam logic [2:0] VerdictNotHs     = 3'd2;
  localparam logic [2:0] VerdictNotHello  = 3'd3;
  localparam logic [2:0] VerdictBadVer    = 3'd4;
  localparam logic [2:0] VerdictTruncated = 3'd5;

  localparam logic KindName    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] name_byte;
    logic [1:0] name_number;
    logic       name_end;
    logic [2:0] verdict;
    logic [2:0] names_found;
    logic       packet_done;
  } out_item_t;

endpackage

FILE: src/tcs_stream_if.sv
// ---------------------------------------------------------------------------
// tcs_stream_if
// valid/ready channel carrying one payload item
// ---------------------------------------------------------------------------
interface tcs_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tls_client_hello_sni_extractor.sv
// ---------------------------------------------------------------------------
// tls_client_hello_sni_extractor
// walks a tls clienthello byte stream and emits server name bytes and a verdict
// ---------------------------------------------------------------------------
// in_if carries one payload byte per word with payload_end on the last byte.
// out_if carries name byte words and one verdict word per payload, the
// verdict flagged by packet_done.
// each accepted byte is parsed in the cycle it is accepted; its results go
// into a two-entry output queue; the first shows on out_if from the next cycle,
// a second once the first has left. throughput is one byte per cycle while the
// queue has room; only the last byte of a payload that is also an emitted name
// byte yields two results, which leave one per cycle while out_if is ready.
// a byte is taken when the queue is empty or its one word leaves in the
// same cycle, so name bytes move at one per cycle while the receiver keeps up.
// when the receiver stalls with a word waiting, in_if ready drops until
// words drain.
// reset puts the parser at the record header with all positions at zero
// and empties the queue.
// ---------------------------------------------------------------------------
module tls_client_hello_sni_extractor #(
  parameter int unsigned MAX_NAMES     = tcs_pkg::MaxNamesDefault,
  parameter int unsigned POSITION_BITS = tcs_pkg::PositionBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcs_stream_if.sink   in_if,
  tcs_stream_if.source out_if
);
  import tcs_pkg::*;
  `include "tls_client_hello_sni_extractor_macros.svh"

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned CB = (MAX_NAMES >= 7) ? 5 : 3;
  localparam logic [PB-1:0] PMax = {PB{1'b1}};

  typedef enum logic [4:0] {
    PhRec, PhHs, PhHsVer, PhRandom, PhSidLen, PhSid, PhCsLen, PhCs,
    PhCompLen, PhComp, PhExtsLen, PhExtHdr, PhExtSkip, PhSniLen, PhSniHdr,
    PhSniName, PhDone, PhErr
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [15:0]   flen_q, flen_d;
  logic [PB-1:0] exts_end_q, exts_end_d;
  logic [PB-1:0] cur_end_q, cur_end_d;
  logic [PB-1:0] sni_end_q, sni_end_d;
  logic [PB-1:0] req_end_q, req_end_d;
  logic [15:0]   ext_type_q, ext_type_d;
  logic [CB-1:0] ncount_q, ncount_d;
  logic [2:0]    err_q, err_d;

  function automatic logic [PB-1:0] padd(logic [PB-1:0] a, logic [24:0] b);
    logic [25:0] s;
    s = {{(26-PB){1'b0}}, a} + {1'b0, b};
    padd = (s > {{(26-PB){1'b0}}, PMax}) ? PMax : s[PB-1:0];
  endfunction

  // output queue
  out_item_t     q_mem_q [2];
  logic          rd_ptr_q, wr_ptr_q;
  logic [1:0]    fill_q, fill_d;

  logic          take;
  logic [7:0]    b;
  logic          last;
  logic [PB-1:0] nxt;
  logic [15:0]   c;
  logic [15:0]   shl;
  logic          emit_name;
  out_item_t     name_item, verd_item;
  logic [2:0]    vcode;
  logic          pop;

  assign in_if.ready = (fill_q == 2'd0) || (fill_q == 2'd1 && out_if.ready);
  assign take  = in_if.valid && in_if.ready;
  assign b     = in_if.data.payload_byte;
  assign last  = in_if.data.payload_end;
  assign nxt   = padd(pos_q, 25'd1);
  assign c     = cnt_q;
  assign shl   = {flen_q[7:0], b};

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    flen_d     = flen_q;
    exts_end_d = exts_end_q;
    cur_end_d  = cur_end_q;
    sni_end_d  = sni_end_q;
    req_end_d  = req_end_q;
    ext_type_d = ext_type_q;
    ncount_d   = ncount_q;
    err_d      = err_q;
    emit_name  = 1'b0;
    name_item  = '0;

    case (phase_q)
      PhRec: begin
        if (c == 16'd0 && b != 8'd22) begin
          err_d = VerdictNotHs; phase_d = PhErr; cnt_d = '0; flen_d = '0;
        end else if ((c == 16'd1 && b != 8'd3) || (c == 16'd2 && b > 8'd3)) begin
          err_d = VerdictBadVer; phase_d = PhErr; cnt_d = '0; flen_d = '0;
        end else if (c == 16'd4) begin
          phase_d = PhHs; cnt_d = '0; flen_d = '0;
        end else begin
          cnt_d = c + 16'd1;
        end
      end
      PhHs: begin
        if (c == 16'd0 && b != 8'd1) begin
          err_d = VerdictNotHello; phase_d = PhErr; cnt_d = '0; flen_d = '0;
        end else begin
          if (c == 16'd1) req_end_d = padd(PB'(9), {1'b0, b, 16'd0});
          if (c == 16'd2) req_end_d = padd(req_end_q, {9'd0, b, 8'd0});
          if (c == 16'd3) begin
            req_end_d = padd(req_end_q, {17'd0, b});
            phase_d = PhHsVer; cnt_d = '0; flen_d = '0;
          end else begin
            cnt_d = c + 16'd1;
          end
        end
      end
      PhHsVer: begin
        if ((c == 16'd0 && b != 8'd3) || (c != 16'd0 && (b < 8'd1 || b > 8'd3))) begin
          err_d = VerdictBadVer; phase_d = PhErr; cnt_d = '0; flen_d = '0;
        end else if (c == 16'd0) begin
          cnt_d = 16'd1;
        end else begin
          phase_d = PhRandom; cnt_d = 16'd32; flen_d = '0;
        end
      end
      PhRandom, PhSid, PhCs, PhComp: begin
        if (c <= 16'd1) begin
          cnt_d = '0; flen_d = '0;
          case (phase_q)
            PhRandom: phase_d = PhSidLen;
            PhSid:    phase_d = PhCsLen;
            PhCs:     phase_d = PhCompLen;
            default:  phase_d = PhExtsLen;
          endcase
        end else begin
          cnt_d = c - 16'd1;
        end
      end
      PhSidLen, PhCompLen: begin
        flen_d = '0;
        cnt_d  = {8'd0, b};
        if (b == 8'd0) phase_d = (phase_q == PhSidLen) ? PhCsLen : PhExtsLen;
        else           phase_d = (phase_q == PhSidLen) ? PhSid : PhComp;
      end
      PhCsLen, PhExtsLen: begin
        if (c == 16'd0) begin
          flen_d = {8'd0, b}; cnt_d = 16'd1;
        end else begin
          flen_d = '0; cnt_d = '0;
          if (phase_q == PhCsLen) begin
            if (shl == 16'd0) phase_d = PhCompLen;
            else begin phase_d = PhCs; cnt_d = shl; end
          end else begin
            exts_end_d = padd(nxt, {9'd0, shl});
            phase_d = (padd(nxt, 25'd4) > padd(nxt, {9'd0, shl})) ? PhDone : PhExtHdr;
          end
        end
      end
      PhExtHdr: begin
        flen_d = shl;
        if (c == 16'd1) begin
          ext_type_d = shl; flen_d = '0; cnt_d = 16'd2;
        end else if (c == 16'd3) begin
          cur_end_d = padd(nxt, {9'd0, shl});
          cnt_d = '0; flen_d = '0;
          if (ext_type_q == 16'd0) phase_d = PhSniLen;
          else if (nxt >= padd(nxt, {9'd0, shl}))
            phase_d = (padd(nxt, 25'd4) > exts_end_q) ? PhDone : PhExtHdr;
          else phase_d = PhExtSkip;
        end else begin
          cnt_d = c + 16'd1;
        end
      end
      PhExtSkip: begin
        if (nxt >= cur_end_q) begin
          cnt_d = '0; flen_d = '0;
          phase_d = (padd(nxt, 25'd4) > exts_end_q) ? PhDone : PhExtHdr;
        end
      end
      PhSniLen: begin
        flen_d = shl;
        if (c == 16'd0) cnt_d = 16'd1;
        else begin
          sni_end_d = padd(nxt, {9'd0, shl});
          cnt_d = '0; flen_d = '0;
          if (padd(nxt, 25'd3) < padd(nxt, {9'd0, shl})) phase_d = PhSniHdr;
          else if (nxt < cur_end_q) phase_d = PhExtSkip;
          else phase_d = (padd(nxt, 25'd4) > exts_end_q) ? PhDone : PhExtHdr;
        end
      end
      PhSniHdr: begin
        if (c >= 16'd1) flen_d = shl;
        if (c < 16'd2) cnt_d = c + 16'd1;
        else begin
          cnt_d = '0; flen_d = '0;
          if (padd(nxt, {9'd0, shl}) > sni_end_q) begin
            if (nxt < cur_end_q) phase_d = PhExtSkip;
            else phase_d = (padd(nxt, 25'd4) > exts_end_q) ? PhDone : PhExtHdr;
          end else if (shl == 16'd0) begin
            if (padd(nxt, 25'd3) < sni_end_q) phase_d = PhSniHdr;
            else if (nxt < cur_end_q) phase_d = PhExtSkip;
            else phase_d = (padd(nxt, 25'd4) > exts_end_q) ? PhDone : PhExtHdr;
          end else begin
            phase_d = PhSniName; cnt_d = shl;
          end
        end
      end
      PhSniName: begin
        emit_name = (32'(ncount_q) < MAX_NAMES);
        name_item.result_kind = KindName;
        name_item.name_byte   = b;
        name_item.name_number = ncount_q[1:0];
        name_item.name_end    = (c <= 16'd1);
        name_item.names_found = ncount_q[2:0];
        if (c <= 16'd1) begin
          if (emit_name) ncount_d = ncount_q + CB'(1);
          cnt_d = '0; flen_d = '0;
          if (padd(nxt, 25'd3) < sni_end_q) phase_d = PhSniHdr;
          else if (nxt < cur_end_q) phase_d = PhExtSkip;
          else phase_d = (padd(nxt, 25'd4) > exts_end_q) ? PhDone : PhExtHdr;
        end else begin
          cnt_d = c - 16'd1;
        end
      end
      default: ;
    endcase

    if (phase_d == PhErr) vcode = err_d;
    else if (phase_d < PhExtHdr || phase_d > PhDone) vcode = VerdictTruncated;
    else if (nxt < req_end_d || nxt < exts_end_d || nxt < sni_end_d)
      vcode = VerdictTruncated;
    else vcode = (ncount_d != '0) ? VerdictOk : VerdictNoName;
    verd_item = '0;
    verd_item.result_kind = KindVerdict;
    verd_item.verdict     = vcode;
    verd_item.names_found = ncount_d[2:0];
    verd_item.packet_done = 1'b1;

    pos_d = nxt;
    if (last) begin
      phase_d = PhRec; cnt_d = '0; flen_d = '0; pos_d = '0;
      exts_end_d = '0; cur_end_d = '0; sni_end_d = '0; req_end_d = '0;
      ext_type_d = '0; ncount_d = '0; err_d = VerdictOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRec; pos_q <= '0; cnt_q <= '0; flen_q <= '0;
      exts_end_q <= '0; cur_end_q <= '0; sni_end_q <= '0; req_end_q <= '0;
      ext_type_q <= '0; ncount_q <= '0; err_q <= VerdictOk;
    end else if (take) begin
      phase_q <= phase_d; pos_q <= pos_d; cnt_q <= cnt_d; flen_q <= flen_d;
      exts_end_q <= exts_end_d; cur_end_q <= cur_end_d; sni_end_q <= sni_end_d;
      req_end_q <= req_end_d; ext_type_q <= ext_type_d; ncount_q <= ncount_d;
      err_q <= err_d;
    end
  end

  assign pop = out_if.valid && out_if.ready;
  assign out_if.valid = (fill_q != 2'd0);
  assign out_if.data  = q_mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q - {1'b0, pop};
    if (take) fill_d = fill_d + {1'b0, emit_name} + {1'b0, last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0; fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (take) wr_ptr_q <= wr_ptr_q ^ emit_name ^ last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit_name) q_mem_q[wr_ptr_q] <= name_item;
    if (take && last) q_mem_q[wr_ptr_q ^ emit_name] <= verd_item;
  end

  `TCS_ASSERT_IMP(a_fill_max, clk_i, rst_ni, 1'b1, fill_q <= 2'd2)
  `TCS_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, take && last, phase_q == PhRec && pos_q == '0)
  `TCS_ASSERT_IMP(a_ready_room, clk_i, rst_ni, in_if.ready, fill_q <= 2'd1)
  `TCS_ASSERT_NEXT(a_err_sticks, clk_i, rst_ni, phase_q == PhErr && !(take && last),
                   phase_q == PhErr)

endmodule

FILE: tb/tls_client_hello_sni_extractor_tb.sv
// ---------------------------------------------------------------------------
// tls_client_hello_sni_extractor_tb
// drives tls payload byte streams into the server name extractor and checks
// every name byte word and verdict word against a cycle-free parser model
// ---------------------------------------------------------------------------
module tls_client_hello_sni_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcs_pkg::*;

  localparam int unsigned MaxNames = MaxNamesDefault;
  localparam int unsigned PosMax   = (1 << PositionBitsDefault) - 1;
  localparam int unsigned WatchdogLimit = 20000;

  typedef enum logic [4:0] {
    PhRec, PhHs, PhHsVer, PhRandom, PhSidLen, PhSid, PhCsLen, PhCs, PhCompLen,
    PhComp, PhExtsLen, PhExtHdr, PhExtSkip, PhSniLen, PhSniHdr, PhSniName,
    PhDone, PhErr
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcs_stream_if #(.item_t(in_item_t))  in_if ();
  tcs_stream_if #(.item_t(out_item_t)) out_if ();

  tls_client_hello_sni_extractor DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #5 clk_i = ~clk_i;

  // parser state
  parse_phase_e phase;
  int unsigned  pos, fcnt, flen, exts_end, ext_end, sni_end, req_end, ext_type;
  int unsigned  name_cnt;
  logic [2:0]   err_code;

  out_item_t expected_words[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;
  bit          random_stall = 1'b1;
  byte unsigned pkt[$];

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    return (a + b > PosMax) ? PosMax : a + b;
  endfunction

  function automatic byte unsigned lo8(int unsigned v);
    return v[7:0];
  endfunction

  function automatic byte unsigned rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void enter(parse_phase_e p);
    phase = p;
    fcnt = 0;
    flen = 0;
  endfunction

  function automatic void reject(logic [2:0] code);
    err_code = code;
    enter(PhErr);
  endfunction

  function automatic void skip_or(int unsigned n, parse_phase_e s, parse_phase_e a);
    if (n == 0) enter(a);
    else begin
      enter(s);
      fcnt = n;
    end
  endfunction

  function automatic void next_ext(int unsigned nx);
    if (sat_add(nx, 4) > exts_end) enter(PhDone);
    else enter(PhExtHdr);
  endfunction

  function automatic void list_over(int unsigned nx);
    if (nx < ext_end) enter(PhExtSkip);
    else next_ext(nx);
  endfunction

  function automatic void list_more(int unsigned nx);
    if (sat_add(nx, 3) < sni_end) enter(PhSniHdr);
    else list_over(nx);
  endfunction

  function automatic void clear_packet();
    enter(PhRec);
    pos = 0; exts_end = 0; ext_end = 0; sni_end = 0; req_end = 0;
    ext_type = 0; name_cnt = 0; err_code = VerdictOk;
  endfunction

  function automatic void parse_byte(byte unsigned b, bit last);
    int unsigned nx, c, len;
    bit emit, fin;
    out_item_t w;
    nx = sat_add(pos, 1);
    c = fcnt;
    case (phase)
      PhRec: begin
        if (c == 0 && b != 22) reject(VerdictNotHs);
        else if (c == 1 && b != 3) reject(VerdictBadVer);
        else if (c == 2 && b > 3) reject(VerdictBadVer);
        else if (c == 4) enter(PhHs);
        else fcnt = c + 1;
      end
      PhHs: begin
        if (c == 0 && b != 1) reject(VerdictNotHello);
        else begin
          if (c == 1) req_end = sat_add(9, 32'(b) << 16);
          if (c == 2) req_end = sat_add(req_end, 32'(b) << 8);
          if (c == 3) begin
            req_end = sat_add(req_end, 32'(b));
            enter(PhHsVer);
          end else fcnt = c + 1;
        end
      end
      PhHsVer: begin
        if (c == 0) begin
          if (b != 3) reject(VerdictBadVer);
          else fcnt = 1;
        end else if (b < 1 || b > 3) reject(VerdictBadVer);
        else skip_or(32, PhRandom, PhSidLen);
      end
      PhRandom, PhSid, PhCs, PhComp: begin
        if (c <= 1) begin
          case (phase)
            PhRandom: enter(PhSidLen);
            PhSid:    enter(PhCsLen);
            PhCs:     enter(PhCompLen);
            default:  enter(PhExtsLen);
          endcase
        end else fcnt = c - 1;
      end
      PhSidLen:  skip_or(32'(b), PhSid, PhCsLen);
      PhCompLen: skip_or(32'(b), PhComp, PhExtsLen);
      PhCsLen, PhExtsLen: begin
        if (c == 0) begin
          flen = 32'(b);
          fcnt = 1;
        end else begin
          len = ((flen << 8) | 32'(b)) & 16'hffff;
          if (phase == PhCsLen) skip_or(len, PhCs, PhCompLen);
          else begin
            exts_end = sat_add(nx, len);
            next_ext(nx);
          end
        end
      end
      PhExtHdr: begin
        flen = ((flen << 8) | 32'(b)) & 16'hffff;
        if (c == 1) begin
          ext_type = flen;
          flen = 0;
          fcnt = 2;
        end else if (c == 3) begin
          ext_end = sat_add(nx, flen);
          if (ext_type == 0) enter(PhSniLen);
          else if (nx >= ext_end) next_ext(nx);
          else enter(PhExtSkip);
        end else fcnt = c + 1;
      end
      PhExtSkip: if (nx >= ext_end) next_ext(nx);
      PhSniLen: begin
        flen = ((flen << 8) | 32'(b)) & 16'hffff;
        if (c == 0) fcnt = 1;
        else begin
          sni_end = sat_add(nx, flen);
          list_more(nx);
        end
      end
      PhSniHdr: begin
        if (c >= 1) flen = ((flen << 8) | 32'(b)) & 16'hffff;
        if (c < 2) fcnt = c + 1;
        else begin
          len = flen;
          if (sat_add(nx, len) > sni_end) list_over(nx);
          else if (len == 0) list_more(nx);
          else begin
            enter(PhSniName);
            fcnt = len;
          end
        end
      end
      PhSniName: begin
        emit = name_cnt < MaxNames;
        fin = c <= 1;
        if (emit) begin
          w = '0;
          w.result_kind = KindName;
          w.name_byte   = b;
          w.name_number = name_cnt[1:0];
          w.name_end    = fin;
          w.names_found = name_cnt[2:0];
          expected_words.push_back(w);
        end
        if (fin) begin
          if (emit) name_cnt++;
          list_more(nx);
        end else fcnt = c - 1;
      end
      default: ;
    endcase
    pos = nx;
    if (last) begin
      w = '0;
      w.result_kind = KindVerdict;
      w.packet_done = 1'b1;
      w.names_found = name_cnt[2:0];
      if (phase == PhErr) w.verdict = err_code;
      else if (phase < PhExtHdr || phase > PhDone) w.verdict = VerdictTruncated;
      else if (nx < req_end || nx < exts_end || nx < sni_end)
        w.verdict = VerdictTruncated;
      else w.verdict = (name_cnt > 0) ? VerdictOk : VerdictNoName;
      expected_words.push_back(w);
      clear_packet();
    end
  endfunction

  // sender
  task automatic send_word(byte unsigned b, bit last, bit no_gap = 1'b0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.data  <= '{payload_byte: b, payload_end: last};
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    parse_byte(b, last);
  endtask

  task automatic send_packet(bit no_gap = 1'b0);
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1, no_gap);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic void put16(int unsigned v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  // builds a clienthello with nn names of random length; corrupt flags mangle it
  function automatic void build_hello(int unsigned nn, int unsigned max_len,
                                      bit truncate, bit bad_len);
    byte unsigned body[$];
    byte unsigned ext[$];
    byte unsigned lst[$];
    int unsigned n, l, hl, cut;
    pkt.delete();
    for (int i = 0; i < nn; i++) begin
      l = $urandom_range(0, max_len);
      lst.push_back(rnd8());
      lst.push_back(lo8(l >> 8));
      lst.push_back(lo8(l));
      repeat (l) lst.push_back(rnd8());
    end
    if ($urandom_range(0, 2) == 0) begin
      ext.push_back(8'h00); ext.push_back(8'h0a);
      n = $urandom_range(0, 4);
      ext.push_back(8'h00); ext.push_back(lo8(n));
      repeat (n) ext.push_back(rnd8());
    end
    ext.push_back(8'h00); ext.push_back(8'h00);
    l = lst.size() + 2 + (bad_len ? $urandom_range(0, 3) : 0);
    ext.push_back(lo8(l >> 8)); ext.push_back(lo8(l));
    l = lst.size() + (bad_len ? $urandom_range(0, 2) : 0);
    ext.push_back(lo8(l >> 8)); ext.push_back(lo8(l));
    foreach (lst[i]) ext.push_back(lst[i]);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5))
      ext.push_back(rnd8());
    body.push_back(8'd3); body.push_back(lo8($urandom_range(1, 3)));
    repeat (32) body.push_back(rnd8());
    n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32) : 0;
    body.push_back(lo8(n));
    repeat (n) body.push_back(rnd8());
    n = 2 * $urandom_range(0, 3);
    body.push_back(8'h00); body.push_back(lo8(n));
    repeat (n) body.push_back(rnd8());
    n = $urandom_range(0, 2);
    body.push_back(lo8(n));
    repeat (n) body.push_back(rnd8());
    body.push_back(lo8(ext.size() >> 8)); body.push_back(lo8(ext.size()));
    foreach (ext[i]) body.push_back(ext[i]);
    hl = body.size();
    pkt.push_back(8'd22); pkt.push_back(8'd3); pkt.push_back(lo8($urandom_range(0, 3)));
    put16(hl + 4);
    pkt.push_back(8'd1); pkt.push_back(8'd0); put16(hl);
    foreach (body[i]) pkt.push_back(body[i]);
    if (truncate) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endfunction

  function automatic void build_noise(int unsigned n);
    pkt.delete();
    repeat (n) pkt.push_back(rnd8());
    if ($urandom_range(0, 1)) pkt[0] = 8'd22;
  endfunction

  // directed header cases: bad record, bad version, not hello, short payloads
  task automatic test_header_errors();
    pkt = '{8'd23}; send_packet();
    pkt = '{8'd22, 8'd2}; send_packet();
    pkt = '{8'd22, 8'd3, 8'd4, 8'd0}; send_packet();
    pkt = '{8'd22, 8'd3, 8'd1, 8'd0, 8'd40, 8'd2, 8'd0}; send_packet();
    pkt = '{8'd22, 8'd3, 8'd3, 8'd0, 8'd40, 8'd1, 8'd0, 8'd0, 8'd36, 8'd2}; send_packet();
    pkt = '{8'd22, 8'd3, 8'd3, 8'd0, 8'd40, 8'd1, 8'd0, 8'd0, 8'd36, 8'd3, 8'd0};
    send_packet();
    pkt = '{8'd22, 8'd3, 8'd3, 8'd0, 8'd40, 8'd1, 8'd0, 8'd0, 8'd36, 8'd3, 8'd4};
    send_packet();
    pkt = '{8'd22, 8'd3, 8'd0, 8'd0, 8'd0, 8'd1, 8'hff, 8'hff, 8'hff}; send_packet();
    pkt = '{8'hff}; send_packet();
    wait_drained();
  endtask

  // none, one, many names over limit, empty, long, bad-length, truncated hellos
  task automatic test_names();
    build_hello(0, 0, 1'b0, 1'b0); send_packet();
    build_hello(1, 1, 1'b0, 1'b0); send_packet();
    build_hello(6, 4, 1'b0, 1'b0); send_packet();
    build_hello(3, 0, 1'b0, 1'b0); send_packet();
    build_hello(2, 300, 1'b0, 1'b0); send_packet();
    build_hello(2, 6, 1'b0, 1'b1); send_packet();
    build_hello(2, 6, 1'b1, 1'b0); send_packet();
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned sent, r;
    sent = 0;
    while (sent < 2000) begin
      r = $urandom_range(0, 9);
      if (r < 6) build_hello($urandom_range(0, 6), 8, 1'b0, r == 5);
      else if (r < 8) build_hello($urandom_range(1, 4), 8, 1'b1, 1'b0);
      else build_noise($urandom_range(1, 12));
      send_packet();
      sent += pkt.size();
    end
    wait_drained();
  endtask

  // receiver stalls long while the sender streams, then sender waits for drain
  task automatic test_backpressure();
    random_stall = 1'b0;
    hold_off = 200;
    build_hello(4, 10, 1'b0, 1'b0); send_packet(1'b1);
    build_hello(5, 10, 1'b0, 1'b0); send_packet(1'b1);
    wait_drained();
    random_stall = 1'b1;
  endtask

  // receiver
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      stall = random_stall && $urandom_range(0, 2) == 0 ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // result check
  always @(posedge clk_i) begin
    out_item_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word exp none act %p", $time, out_if.data);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_if.data !== exp_w) begin
          $display("%0t: word mismatch exp %p act %p", $time, exp_w, out_if.data);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tls_client_hello_sni_extractor_tb: FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    clear_packet();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_errors();
    test_names();
    test_backpressure();
    test_random();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("tls_client_hello_sni_extractor_tb: PASS");
    end else begin
      $display("tls_client_hello_sni_extractor_tb: FAIL");
    end
    $finish;
  end
endmodule
